/* hw/rtl/sorted_key_value_table_top_assert.svh */
// Assertion macros for the sorted key/value table.
// Used by sorted_key_value_table_top; needs clk_i and rst_ni in scope.
`ifndef SORTED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// Property checked on every clock, off during reset.
`define SKVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold.
`define SKVT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/skvt_pkg.sv */
// Shared types and constants for the sorted key/value table.
// No dependencies.
`default_nettype none

package skvt_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned ADDR_BITS   = 64;
  localparam int unsigned COUNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_COMPARE,
    CELL_INSERT,
    CELL_UPDATE,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_FIND,
    S_APPLY,
    S_SEND
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] address;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    logic        full_res;
    logic [6:0]  count;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] key;
    logic [31:0]          value;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   entry;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/skvt_cell.sv */
// One slot of the sorted table: key, value and compare flags.
// Depends on skvt_pkg.
`default_nettype none

module skvt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skvt_pkg::cell_cmd_t cmd_i,
  input  logic               occ_i,
  input  logic               prev_ge_i,
  input  skvt_pkg::entry_t   left_i,
  input  skvt_pkg::entry_t   right_i,
  output skvt_pkg::entry_t   entry_o,
  output logic               ge_o,
  output logic               eq_o
);
  import skvt_pkg::*;

  entry_t entry_q, entry_d;
  logic   ge_q, ge_d, eq_q, eq_d;

  always_comb begin
    entry_d = entry_q;
    ge_d    = ge_q;
    eq_d    = eq_q;
    case (cmd_i.op)
      CELL_COMPARE: begin
        eq_d = occ_i && (entry_q.key == cmd_i.entry.key);
        ge_d = !occ_i || (entry_q.key >= cmd_i.entry.key);
      end
      CELL_INSERT: begin
        if (ge_q) begin
          entry_d = prev_ge_i ? left_i : cmd_i.entry;
        end
      end
      CELL_UPDATE: begin
        if (eq_q) begin
          entry_d.value = cmd_i.entry.value;
        end
      end
      CELL_REMOVE: begin
        if (ge_q) begin
          entry_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      ge_q <= ge_d;
      eq_q <= eq_d;
    end
  end

  assign entry_o = entry_q;
  assign ge_o    = ge_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_key_value_table_top.sv */
// One item in flight at a time: a new item is taken only after the previous result has
// been loaded into the output register, which waits while the result side stalls.
// Steps: cell compare, hit reduction over all cells, shift/update in the cell chain,
// result register. Reset clears the entry count and control state; slots need no clearing.
// Top level of the sorted key/value table: controller and chain of cells.
// Depends on skvt_pkg, skvt_cell and sorted_key_value_table_top_assert.svh.
`default_nettype none

`include "sorted_key_value_table_top_assert.svh"

module sorted_key_value_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  skvt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output skvt_pkg::rsp_t out_rsp_o
);
  import skvt_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic   req_en;
  logic [COUNT_W-1:0] count_q, count_d;
  logic   found_q, found_d;
  logic [31:0] hitval_q, hitval_d;
  rsp_t   res_q, res_d;
  logic   res_en;
  rsp_t   out_q;
  logic   out_valid_q, out_valid_d, out_load;
  cell_cmd_t cmd;

  entry_t           entry  [DEPTH];
  logic [DEPTH-1:0] ge_vec, eq_vec, occ_vec;
  logic is_set, is_remove, tbl_full;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ_vec[g] = count_q > COUNT_W'(g);
    skvt_cell u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i     (cmd),
      .occ_i     (occ_vec[g]),
      .prev_ge_i ((g == 0) ? 1'b0 : ge_vec[(g == 0) ? 0 : g - 1]),
      .left_i    (entry[(g == 0) ? 0 : g - 1]),
      .right_i   (entry[(g == DEPTH - 1) ? g : g + 1]),
      .entry_o   (entry[g]),
      .ge_o      (ge_vec[g]),
      .eq_o      (eq_vec[g])
    );
  end

  always_comb begin
    found_d  = 1'b0;
    hitval_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_d  = found_d | eq_vec[i];
      hitval_d = hitval_d | (eq_vec[i] ? entry[i].value : 32'd0);
    end
  end

  assign is_set    = req_q.op == OP_SET;
  assign is_remove = req_q.op == OP_REMOVE;
  assign tbl_full  = count_q == COUNT_W'(DEPTH);

  always_comb begin
    state_d     = state_q;
    req_en      = 1'b0;
    res_en      = 1'b0;
    out_load    = 1'b0;
    count_d     = count_q;
    in_ready_o  = 1'b0;
    cmd.op      = CELL_HOLD;
    cmd.entry.key   = req_q.address[ADDR_BITS-1:0];
    cmd.entry.value = req_q.value_in;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_en  = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd.op  = CELL_COMPARE;
        state_d = S_FIND;
      end
      S_FIND: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (is_set) begin
          if (found_q) begin
            cmd.op = CELL_UPDATE;
          end else if (!tbl_full) begin
            cmd.op  = CELL_INSERT;
            count_d = count_q + COUNT_W'(1);
          end
        end else if (is_remove && found_q) begin
          cmd.op  = CELL_REMOVE;
          count_d = count_q - COUNT_W'(1);
        end
        res_en          = 1'b1;
        res_d.hit       = found_q;
        res_d.value_out = (!is_set && found_q) ? hitval_q : 32'd0;
        res_d.full_res  = is_set && !found_q && tbl_full;
        res_d.count     = COUNT_OUT_W'(count_d);
        state_d         = S_SEND;
      end
      S_SEND: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_en) begin
      req_q <= in_req_i;
    end
    if (state_q == S_FIND) begin
      found_q  <= found_d;
      hitval_q <= hitval_d;
    end
    if (res_en) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SKVT_ASSERT(a_count_bound, count_q <= COUNT_W'(DEPTH), "entry count above depth")
  `SKVT_ASSERT(a_key_unique, state_q == S_FIND |-> $onehot0(eq_vec), "duplicate key in table")
  `SKVT_ASSERT_NEVER(a_full_hit, out_valid_q && out_q.full_res && out_q.hit,
    "refused set reported as hit")
  `SKVT_ASSERT(a_accept_cmp, in_valid_i && in_ready_o |=> state_q == S_CMP,
    "accepted item did not start compare")

endmodule

`default_nettype wire
